// ===== rtl/kwm_pkg.sv =====
// Shared types, constants and the ordering function for the k-way merge unit.
// Depends on nothing; every other file refers to it by scoped names.
package kwm_pkg;

  localparam int NUM_SOURCES = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int FIELD_WIDTH = 32;
  localparam int SOURCE_WIDTH = 4;

  typedef struct packed {
    logic                          mode;
    logic                          present;
    logic signed [FIELD_WIDTH-1:0] value;
    logic [SOURCE_WIDTH-1:0]       source;
  } kwm_in_t;

  typedef struct packed {
    logic                          found;
    logic signed [FIELD_WIDTH-1:0] min_value;
    logic [SOURCE_WIDTH-1:0]       min_source;
    logic                          last;
  } kwm_out_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [SOURCE_WIDTH-1:0]       source;
  } kwm_entry_t;

  typedef struct packed {
    logic       ins;
    logic       pop;
    kwm_entry_t entry;
  } kwm_op_t;

  typedef struct packed {
    logic       valid;
    logic       lt;
    kwm_entry_t entry;
  } kwm_link_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } kwm_state_t;

  // True if a leaves the store before b: lower value first, then lower source.
  function automatic logic entry_before(kwm_entry_t a, kwm_entry_t b);
    if (a.value != b.value) begin
      return a.value < b.value;
    end
    return a.source < b.source;
  endfunction

endpackage

// ===== rtl/kwm_in_if.sv =====
// Input channel of the merge unit: valid, ready and one input beat.
// Depends on kwm_pkg for the payload type.
interface kwm_in_if;
  logic             valid;
  logic             ready;
  kwm_pkg::kwm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/kwm_out_if.sv =====
// Result channel of the merge unit: valid, ready and one result beat.
// Depends on kwm_pkg for the payload type.
interface kwm_out_if;
  logic              valid;
  logic              ready;
  kwm_pkg::kwm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/kwm_cell.sv =====
// One cell of the sorted row: holds a single entry and its valid bit.
// Depends on kwm_pkg; exchanges entries with both neighbors on insert and pop.
module kwm_cell (
  input  logic               clk,
  input  logic               rst,
  input  kwm_pkg::kwm_op_t   op,
  input  kwm_pkg::kwm_link_t prev,
  input  kwm_pkg::kwm_link_t next,
  output kwm_pkg::kwm_link_t self
);

  logic               valid;
  kwm_pkg::kwm_entry_t entry;
  logic               lt;

  assign lt = !valid || kwm_pkg::entry_before(op.entry, entry);

  assign self.valid = valid;
  assign self.lt    = lt;
  assign self.entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.pop) begin
      valid <= next.valid;
    end else if (op.ins) begin
      valid <= valid | prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op.pop) begin
      entry <= next.entry;
    end else if (op.ins && lt) begin
      entry <= prev.lt ? prev.entry : op.entry;
    end
  end

endmodule

// ===== rtl/k_way_merge_min_heap_unit.sv =====
// Top level of the k-way merge unit: a sorted row of cells and a result register.
// Depends on kwm_pkg, kwm_in_if, kwm_out_if and kwm_cell.
//
//   channel  dir  beat
//   feed     in   mode, present, value, source
//   result   out  found, min_value, min_source, last
//
// A load beat only inserts; a pop beat inserts and then, from state ST_POP, pops.
// Every cell compares the new entry at once, so all cells update together on the insert.
// Reset clears the valid bit of every cell; the store is empty and ready at once.
// A pending result holds the pop back, and no new beat is accepted until the pop is done.
module k_way_merge_min_heap_unit (
  input logic      clk,
  input logic      rst,
  kwm_in_if.sink   feed,
  kwm_out_if.source result
);

  localparam int N = kwm_pkg::NUM_SOURCES;

  kwm_pkg::kwm_state_t state;
  kwm_pkg::kwm_state_t state_next;
  kwm_pkg::kwm_op_t    op;
  kwm_pkg::kwm_link_t  cell_link [N];
  kwm_pkg::kwm_link_t  prev_link [N];
  kwm_pkg::kwm_link_t  next_link [N];
  logic                out_valid;
  kwm_pkg::kwm_out_t   out_data;
  logic                feed_fire;
  logic                slot_free;
  logic                full;

  assign feed.ready = !rst && (state == kwm_pkg::ST_IDLE);
  assign feed_fire  = feed.valid && feed.ready;
  assign slot_free  = !out_valid || result.ready;
  assign full       = cell_link[N-1].valid;

  always_comb begin
    state_next      = state;
    op.ins          = 1'b0;
    op.pop          = 1'b0;
    op.entry.value  = kwm_pkg::VALUE_WIDTH'(feed.data.value);
    op.entry.source = feed.data.source;
    unique case (state)
      kwm_pkg::ST_IDLE: begin
        if (feed_fire) begin
          op.ins = feed.data.present && !full;
          if (feed.data.mode) begin
            state_next = kwm_pkg::ST_POP;
          end
        end
      end
      kwm_pkg::ST_POP: begin
        if (slot_free) begin
          op.pop     = 1'b1;
          state_next = kwm_pkg::ST_IDLE;
        end
      end
      default: state_next = kwm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kwm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      if (i == 0) begin : g_first
        assign prev_link[i].valid = 1'b1;
        assign prev_link[i].lt    = 1'b0;
        assign prev_link[i].entry = '0;
      end else begin : g_inner
        assign prev_link[i] = cell_link[i-1];
      end
      if (i == N - 1) begin : g_last
        assign next_link[i].valid = 1'b0;
        assign next_link[i].lt    = 1'b0;
        assign next_link[i].entry = '0;
      end else begin : g_body
        assign next_link[i] = cell_link[i+1];
      end
      kwm_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .op   (op),
        .prev (prev_link[i]),
        .next (next_link[i]),
        .self (cell_link[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op.pop) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op.pop) begin
      out_data.found <= cell_link[0].valid;
      out_data.last  <= !cell_link[1].valid;
      if (cell_link[0].valid) begin
        out_data.min_value  <= kwm_pkg::FIELD_WIDTH'(cell_link[0].entry.value);
        out_data.min_source <= cell_link[0].entry.source;
      end else begin
        out_data.min_value  <= '0;
        out_data.min_source <= '0;
      end
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule
